### src/rsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsd_pkg
// shared constants for the ray / sphere distance pipeline
// ----------------------------------------------------------------------------
package rsd_pkg;

   localparam int CoordW  = 32;
   localparam int DotW    = 66;
   localparam int PdW     = 36;
   localparam int NormW   = 64;
   localparam int SqW     = 71;
   localparam int DiscW   = 73;
   localparam int RadW    = 64;
   localparam int RootW   = 32;
   localparam int RemW    = 66;
   localparam int DistW   = 38;
   localparam int MarginW = 17;
   localparam int TolW    = 32;
   localparam int IdxW    = 1;

   localparam logic [IdxW-1:0] REG_MARGIN = 1'b0;
   localparam logic [IdxW-1:0] REG_TOL    = 1'b1;

   localparam logic [MarginW-1:0] MARGIN_RESET = 17'd1;
   localparam logic [TolW-1:0]    TOL_RESET    = 32'd256;

   // largest positive q32.32 value
   localparam logic [RadW-1:0] RAD_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

endpackage
`default_nettype wire

### src/ray_sphere_distance_top.sv
`default_nettype none
// pipeline: 5 arithmetic stages, 32 root stages at one root bit each, one
// result stage
// throughput: one beat per cycle; the whole pipe advances unless a finished
// result is waiting and rsp_tready is low
// reset: synchronous, clears all valid bits and loads the register defaults
// (margin 1, tangent tolerance 256)
// ----------------------------------------------------------------------------
// ray_sphere_distance_top
// fixed-point distance from a ray start to an origin-centred sphere
// ----------------------------------------------------------------------------
module ray_sphere_distance_top (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, sphere_radius
   input  wire logic [223:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // path_length
   output logic [31:0]       rsp_tdata,
   // hit
   output logic              rsp_tuser,
   input  wire logic         csr_we,
   input  wire logic [rsd_pkg::IdxW-1:0] csr_addr,
   input  wire logic [31:0]  csr_wdata
);

   localparam int NSq = rsd_pkg::RootW;

   logic [rsd_pkg::MarginW-1:0] margin_ff;
   logic [rsd_pkg::TolW-1:0]    tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= rsd_pkg::MARGIN_RESET;
         tol_ff    <= rsd_pkg::TOL_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            rsd_pkg::REG_MARGIN: margin_ff <= csr_wdata[rsd_pkg::MarginW-1:0];
            rsd_pkg::REG_TOL:    tol_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic adv;
   logic out_v_ff;
   assign adv        = !out_v_ff || rsp_tready;
   assign req_tready = adv;

   // stage 1: products
   logic signed [31:0] px, py, pz, dx, dy, dz, rad;
   assign px  = req_tdata[31:0];
   assign py  = req_tdata[63:32];
   assign pz  = req_tdata[95:64];
   assign dx  = req_tdata[127:96];
   assign dy  = req_tdata[159:128];
   assign dz  = req_tdata[191:160];
   assign rad = req_tdata[223:192];

   logic              v1_ff, ok1_ff;
   logic signed [63:0] pdx_ff, pdy_ff, pdz_ff, ppx_ff, ppy_ff, ppz_ff, rr1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_tvalid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         ok1_ff <= (rad > 32'sd0);
         pdx_ff <= px * dx;
         pdy_ff <= py * dy;
         pdz_ff <= pz * dz;
         ppx_ff <= px * px;
         ppy_ff <= py * py;
         ppz_ff <= pz * pz;
         rr1_ff <= rad * rad;
      end
   end

   // stage 2: dot product floor and squared norm
   logic [rsd_pkg::DotW-1:0] dot_in;
   logic [rsd_pkg::NormW-1:0] norm_in;
   assign dot_in = {{2{pdx_ff[63]}}, pdx_ff} + {{2{pdy_ff[63]}}, pdy_ff}
                 + {{2{pdz_ff[63]}}, pdz_ff};
   assign norm_in = ppx_ff + ppy_ff + ppz_ff;

   logic                      v2_ff, ok2_ff;
   logic [rsd_pkg::PdW-1:0]   pd2_ff;
   logic [rsd_pkg::NormW-1:0] norm2_ff;
   logic [63:0]               rr2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         ok2_ff   <= ok1_ff;
         pd2_ff   <= dot_in[rsd_pkg::DotW-1:30];
         norm2_ff <= norm_in;
         rr2_ff   <= rr1_ff;
      end
   end

   // stage 3: split square of the dot product, c = r^2 - |p|^2
   logic [rsd_pkg::PdW-1:0] pd_abs;
   assign pd_abs = pd2_ff[rsd_pkg::PdW-1] ? (~pd2_ff + 36'd1) : pd2_ff;

   logic                    v3_ff, ok3_ff;
   logic [rsd_pkg::PdW-1:0] pd3_ff;
   logic [63:0]             ll_ff;
   logic [35:0]             hl_ff;
   logic [7:0]              hh_ff;
   logic [65:0]             c3_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         ok3_ff <= ok2_ff;
         pd3_ff <= pd2_ff;
         ll_ff  <= {32'd0, pd_abs[31:0]} * {32'd0, pd_abs[31:0]};
         hl_ff  <= {32'd0, pd_abs[35:32]} * {4'd0, pd_abs[31:0]};
         hh_ff  <= {4'd0, pd_abs[35:32]} * {4'd0, pd_abs[35:32]};
         c3_ff  <= {2'b00, rr2_ff} - {2'b00, norm2_ff};
      end
   end

   // stage 4: discriminant
   logic [rsd_pkg::SqW-1:0]   sq;
   logic [rsd_pkg::DiscW-1:0] disc_in;
   assign sq = {7'd0, ll_ff} + ({35'd0, hl_ff} << 33) + ({63'd0, hh_ff} << 64);
   assign disc_in = {2'b00, sq} + {{7{c3_ff[65]}}, c3_ff};

   logic                      v4_ff, ok4_ff;
   logic [rsd_pkg::PdW-1:0]   pd4_ff;
   logic [rsd_pkg::DiscW-1:0] disc_ff;

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= v3_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         ok4_ff  <= ok3_ff;
         pd4_ff  <= pd3_ff;
         disc_ff <= disc_in;
      end
   end

   // stage 5: tangent tolerance and saturation
   logic [rsd_pkg::DiscW-1:0] disc_mag;
   logic                      ok5_in;
   logic [rsd_pkg::RadW-1:0]  rad5_in;
   assign disc_mag = ~disc_ff + 73'd1;

   always_comb begin
      ok5_in  = ok4_ff;
      rad5_in = '0;
      if (disc_ff[rsd_pkg::DiscW-1]) begin
         if (disc_mag >= {41'd0, tol_ff}) ok5_in = 1'b0;
      end else if (disc_ff > {9'd0, rsd_pkg::RAD_MAX}) begin
         rad5_in = rsd_pkg::RAD_MAX;
      end else begin
         rad5_in = disc_ff[rsd_pkg::RadW-1:0];
      end
   end

   // root pipeline, stage k decides root bit NSq-1-k
   logic                      sv_ff   [0:NSq];
   logic                      sok_ff  [0:NSq];
   logic [rsd_pkg::PdW-1:0]   spd_ff  [0:NSq];
   logic [rsd_pkg::RemW-1:0]  srem_ff [0:NSq];
   logic [rsd_pkg::RootW-1:0] sroot_ff[0:NSq];

   always_ff @(posedge clock) begin
      if (reset) sv_ff[0] <= 1'b0;
      else if (adv) sv_ff[0] <= v4_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         sok_ff[0]   <= ok5_in;
         spd_ff[0]   <= pd4_ff;
         srem_ff[0]  <= {2'b00, rad5_in};
         sroot_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < NSq; k++) begin : g_sqrt
      localparam int B = NSq - 1 - k;
      logic [rsd_pkg::RemW-1:0] trial;
      assign trial = ({34'd0, sroot_ff[k]} << (B + 1))
                   + ({{(rsd_pkg::RemW-1){1'b0}}, 1'b1} << (2 * B));

      always_ff @(posedge clock) begin
         if (reset) sv_ff[k+1] <= 1'b0;
         else if (adv) sv_ff[k+1] <= sv_ff[k];
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sok_ff[k+1] <= sok_ff[k];
            spd_ff[k+1] <= spd_ff[k];
            if (srem_ff[k] >= trial) begin
               srem_ff[k+1]  <= srem_ff[k] - trial;
               sroot_ff[k+1] <= sroot_ff[k] | (32'd1 << B);
            end else begin
               srem_ff[k+1]  <= srem_ff[k];
               sroot_ff[k+1] <= sroot_ff[k];
            end
         end
      end
   end

   // result stage: nearest root beyond the margin, saturated
   logic signed [rsd_pkg::DistW-1:0] neg_pd, near_d, far_d, thr, pick;
   logic                             hit_in;
   logic [31:0]                      len_in;

   assign neg_pd = -{{2{spd_ff[NSq][rsd_pkg::PdW-1]}}, spd_ff[NSq]};
   assign near_d = neg_pd - $signed({6'd0, sroot_ff[NSq]});
   assign far_d  = neg_pd + $signed({6'd0, sroot_ff[NSq]});
   assign thr    = $signed({18'd0, margin_ff, 3'b000});

   always_comb begin
      hit_in = 1'b0;
      pick   = '0;
      if (sok_ff[NSq]) begin
         if (near_d > thr) begin
            hit_in = 1'b1;
            pick   = near_d;
         end else if (far_d > thr) begin
            hit_in = 1'b1;
            pick   = far_d;
         end
      end
      len_in = (pick[37:32] != 6'd0) ? 32'hFFFF_FFFF : pick[31:0];
   end

   logic        hit_ff;
   logic [31:0] len_ff;

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (adv) out_v_ff <= sv_ff[NSq];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff <= hit_in;
         len_ff <= len_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = len_ff;
   assign rsp_tuser  = hit_ff;

endmodule
`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives ray / sphere queries into ray_sphere_distance_top with random gaps and
// back-pressure, predicts hit and path length in fixed point, checks each beat
// ----------------------------------------------------------------------------
module tb;

   typedef struct {
      logic signed [31:0] px, py, pz, dx, dy, dz, rad;
   } query_type;

   typedef struct {
      logic        hit;
      logic [31:0] len;
   } answer_type;

   localparam int Latency  = 38;
   localparam int StallMax = 200000;
   localparam logic signed [31:0] One30 = 32'sh4000_0000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [223:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         csr_we = 1'b0;
   logic [rsd_pkg::IdxW-1:0] csr_addr = rsd_pkg::REG_MARGIN;
   logic [31:0]  csr_wdata = '0;

   query_type  pending_q[$];
   answer_type answer_q[$];
   logic [16:0] margin = rsd_pkg::MARGIN_RESET;
   logic [31:0] tolerance = rsd_pkg::TOL_RESET;
   int  errors = 0;
   int  send_gap = 0, recv_gap = 0, idle_cycles = 0;
   bit  hold_send = 1'b1;

   ray_sphere_distance_top dut (.*);

   always #1 clock = ~clock;

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic answer_type predict_distance(query_type q);
      answer_type a;
      logic signed [127:0] dot, norm, discw, pd, disc, root, first, second, thr, best;
      bit found;
      a.hit = 1'b0;
      a.len = '0;
      found = 0;
      best = 0;
      if (q.rad <= 0) return a;
      dot = 128'(q.px) * 128'(q.dx) + 128'(q.py) * 128'(q.dy) + 128'(q.pz) * 128'(q.dz);
      norm = 128'(q.px) * 128'(q.px) + 128'(q.py) * 128'(q.py)
           + 128'(q.pz) * 128'(q.pz);
      pd = dot >>> 30;
      discw = pd * pd - norm + 128'(q.rad) * 128'(q.rad);
      // clamp to signed q32.32
      if (discw > 128'sh7FFF_FFFF_FFFF_FFFF) disc = 128'sh7FFF_FFFF_FFFF_FFFF;
      else if (discw < -128'sh8000_0000_0000_0000) disc = -128'sh8000_0000_0000_0000;
      else disc = discw;
      if (disc < 0) begin
         if (-disc < 128'(tolerance)) disc = 0;
         else return a;
      end
      root = 128'(int_sqrt(disc[63:0]));
      first = -pd - root;
      second = -pd + root;
      thr = 128'(margin) * 8;
      if (first > thr) begin
         best = first;
         found = 1;
      end
      if (second > thr && (!found || second < best)) begin
         best = second;
         found = 1;
      end
      if (found) begin
         a.hit = 1'b1;
         a.len = (best > 128'sh FFFF_FFFF) ? 32'hFFFF_FFFF : best[31:0];
      end
      return a;
   endfunction

   function automatic logic [223:0] pack_query(query_type q);
      return {q.rad, q.dz, q.dy, q.dx, q.pz, q.py, q.px};
   endfunction

   task automatic queue_query(query_type q);
      pending_q.insert(pending_q.size(), q);
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      int gap;
      if (req_tvalid && req_tready) begin
         answer_q.insert(answer_q.size(), predict_distance(pending_q.pop_front()));
         gap = $urandom_range(0, 19) * ($urandom_range(0, 3) != 0);
         if (gap == 0 && !hold_send && pending_q.size() != 0) begin
            // next beat follows with no gap
            req_tdata <= pack_query(pending_q[0]);
         end else begin
            send_gap <= gap;
            req_tvalid <= 1'b0;
         end
      end else if (!req_tvalid && !reset && !hold_send && pending_q.size() != 0) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata <= pack_query(pending_q[0]);
         end
      end
   end

   // monitor, with its own random stall
   always @(posedge clock) begin
      answer_type want;
      if (rsp_tvalid && rsp_tready) begin
         if (answer_q.size() == 0) begin
            report_mismatch("unexpected beat", rsp_tdata, 32'd0);
         end else begin
            want = answer_q.pop_front();
            if (rsp_tuser !== want.hit)
               report_mismatch("hit", 32'(rsp_tuser), 32'(want.hit));
            if (rsp_tdata !== want.len) report_mismatch("path_length", rsp_tdata, want.len);
         end
         recv_gap = $urandom_range(0, 19) * ($urandom_range(0, 3) != 0);
         rsp_tready <= (recv_gap == 0);
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_tready <= (recv_gap == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallMax) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
         default: return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
      endcase
   endfunction

   function automatic query_type make_query(bit unit, bit aimed);
      query_type q;
      int ax;
      q.px = rand_word();
      q.py = rand_word();
      q.pz = rand_word();
      q.rad = rand_word();
      if (unit) begin
         // axis-aligned unit direction; aimed rays run along x back towards the centre
         ax = $urandom_range(0, 2);
         q.dx = 0;
         q.dy = 0;
         q.dz = 0;
         if (aimed) begin
            q.py = $urandom_range(0, 3) == 0 ? rand_word() : 0;
            q.pz = 0;
            q.px = $signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
            q.dx = q.px > 0 ? -One30 : One30;
            q.rad = $urandom_range(0, 32'h1FFF_FFFF);
         end else begin
            case (ax)
               0: q.dx = $urandom_range(0, 1) ? One30 : -One30;
               1: q.dy = $urandom_range(0, 1) ? One30 : -One30;
               default: q.dz = $urandom_range(0, 1) ? One30 : -One30;
            endcase
         end
      end else begin
         q.dx = $signed($urandom_range(0, 32'h8000_0000)) - One30;
         q.dy = $signed($urandom_range(0, 32'h8000_0000)) - One30;
         q.dz = $signed($urandom_range(0, 32'h8000_0000)) - One30;
      end
      return q;
   endfunction

   function automatic query_type directed(logic signed [31:0] px, logic signed [31:0] dx,
                                          logic signed [31:0] py, logic signed [31:0] rad);
      query_type q;
      q.px = px; q.py = py; q.pz = 0;
      q.dx = dx; q.dy = 0; q.dz = 0;
      q.rad = rad;
      return q;
   endfunction

   task automatic drain_and_settle();
      while (pending_q.size() != 0 || req_tvalid || answer_q.size() != 0)
         @(posedge clock);
      hold_send = 1'b1;
      repeat (Latency + 4) @(posedge clock);
   endtask

   task automatic write_reg(logic [rsd_pkg::IdxW-1:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == rsd_pkg::REG_MARGIN) margin = val[16:0];
      else tolerance = val;
   endtask

   task automatic run_phase(int count);
      for (int i = 0; i < count; i++)
         queue_query(make_query($urandom_range(0, 3) != 0, $urandom_range(0, 1)));
      hold_send = 1'b0;
      drain_and_settle();
   endtask

   initial begin
      query_type q;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: misses, hits from outside and inside, tangent, extremes
      queue_query(directed(32'sh000A_0000, -One30, 0, 32'sh0001_0000));
      queue_query(directed(32'sh000A_0000, -One30, 0, 0));
      queue_query(directed(32'sh000A_0000, -One30, 0, 32'sh8000_0000));
      queue_query(directed(32'sh000A_0000, One30, 0, 32'sh0001_0000));
      queue_query(directed(0, One30, 0, 32'sh0001_0000));
      queue_query(directed(0, One30, 0, 32'sh7FFF_FFFF));
      queue_query(directed(32'sh000A_0000, -One30, 32'sh0001_0000, 32'sh0001_0000));
      queue_query(directed(32'sh000A_0000, -One30, 32'sh0001_0001, 32'sh0001_0000));
      queue_query(directed(32'sh000A_0000, -One30, 32'sh0000_FFFF, 32'sh0001_0000));
      queue_query(directed(32'sh8000_0000, One30, 0, 32'sh7FFF_FFFF));
      queue_query(directed(32'sh7FFF_FFFF, -One30, 32'sh8000_0000, 32'sh7FFF_FFFF));
      queue_query(directed(0, One30, 0, 32'sh0000_0008));
      queue_query(directed(0, One30, 0, 32'sh0000_0009));
      q = directed(32'sh7FFF_FFFF, 32'shC000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      q.pz = 32'sh8000_0000; q.dy = One30; q.dz = 32'shFFFF_FFFF;
      queue_query(q);
      hold_send = 1'b0;
      drain_and_settle();
      write_reg(rsd_pkg::REG_MARGIN, 32'd0);
      write_reg(rsd_pkg::REG_TOL, 32'd0);
      run_phase(150);
      write_reg(rsd_pkg::REG_MARGIN, 32'h0001_0000);
      write_reg(rsd_pkg::REG_TOL, 32'hFFFF_FFFF);
      run_phase(150);
      write_reg(rsd_pkg::REG_MARGIN, $urandom_range(0, 32'h0001_0000));
      write_reg(rsd_pkg::REG_TOL, $urandom);
      run_phase(150);
      write_reg(rsd_pkg::REG_MARGIN, 32'(rsd_pkg::MARGIN_RESET));
      write_reg(rsd_pkg::REG_TOL, rsd_pkg::TOL_RESET);
      run_phase(150);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
